// ===== rtl/core/pwli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolation table.
// Depends on nothing; imported by the queue, the engine and the top level.
package pwli_pkg;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   // One queued item between front and back.
   typedef struct packed {
      logic        cmd;
      logic [7:0]  row_index;
      logic [2:0]  col_index;
      logic [31:0] value;
   } item_type;

endpackage

// ===== rtl/core/pwli_queue.sv =====
// Short queue that decouples the front stage from the back engine.
// Depends on pwli_pkg for the item type and depth.
module pwli_queue
   import pwli_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   slot_ff [QUEUE_DEPTH];
   logic [0:0] wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign push_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== rtl/core/pwli_divider.sv =====
// Restoring divider: floor((dx << 16) / span), one quotient bit per cycle.
// Standalone; used by the back engine of the interpolation table.
module pwli_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   // dx < span, so the quotient fits 16 bits and the remainder stays below span.
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff;
   logic [15:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic [33:0] trial;

   assign trial    = {rem_ff, 1'b0} - {2'b0, div_ff};
   assign rem_in   = trial[33] ? {rem_ff[31:0], 1'b0} : trial[32:0];
   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == 5'd16);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         div_ff <= divisor;
      end else if (busy_ff && !done) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[14:0], ~trial[33]};
      end
   end

endmodule

// ===== rtl/core/pwli_engine.sv =====
// Back engine: table memory, breakpoint search, division and interpolation.
// Depends on pwli_pkg and pwli_divider.
module pwli_engine
   import pwli_pkg::*;
#(
   parameter int ROWS = 256,
   parameter int COLS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item,
   input  logic [8:0]  row_count,
   input  logic [3:0]  col_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_column,
   output logic [31:0] rsp_interp_value,
   output logic        rsp_found,
   output logic        rsp_last
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam int AW = RW + CW;
   localparam int CMAX = (COLS < 8) ? COLS : 8;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RDX   = 4'd1;
   localparam logic [3:0] S_CMPX  = 4'd2;
   localparam logic [3:0] S_RDY0  = 4'd3;
   localparam logic [3:0] S_RDY1  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_SUM   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_WAIT  = 4'd9;
   localparam logic [3:0] S_RDX0  = 4'd10;

   logic signed [31:0] mem [ROWS*COLS];
   logic signed [31:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [AW-1:0]      wr_addr;

   logic [3:0]         state_ff;
   item_type           cur_ff;
   logic [RW:0]        k_ff;
   logic [RW:0]        rows_lim;
   logic [3:0]         cols_lim;
   logic [3:0]         col_ff;
   logic signed [31:0] xk_ff, y0_ff;
   logic signed [32:0] dy_ff;
   logic [15:0]        q_ff;
   logic signed [49:0] prod_ff;
   logic signed [49:0] sum_wide;
   logic               div_done;
   logic               div_go_ff;
   logic [15:0]        div_q;
   logic [31:0]        dx_w, span_w;
   logic [31:0]        span_w_ff;

   logic               out_valid_ff;
   logic [2:0]         out_col_ff;
   logic [31:0]        out_val_ff;
   logic               out_found_ff, out_last_ff;

   // Clamp configuration to what the table holds.
   assign rows_lim = (32'(row_count) > ROWS) ? (RW+1)'(ROWS) : (RW+1)'(row_count);
   assign cols_lim = (32'(col_count) > CMAX) ? 4'(CMAX) : col_count;

   // Loads write straight into the memory from the queue head.
   assign item_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign mem_we  = item_valid && item_ready && (item.cmd == CMD_LOAD)
                    && (32'(item.row_index) < 32'(ROWS))
                    && (32'(item.col_index) < 32'(COLS));
   assign wr_addr = AW'((32'(item.row_index) * COLS) + 32'(item.col_index));

   // Read address follows the state.
   always_comb begin
      case (state_ff)
         S_RDX0:  rd_addr = AW'(32'(k_ff) * COLS);
         S_CMPX:  rd_addr = AW'(32'(k_ff + 1'b1) * COLS);
         S_RDY0:  rd_addr = AW'((32'(k_ff) * COLS) + 32'(col_ff));
         S_RDY1:  rd_addr = AW'((32'(k_ff + 1'b1) * COLS) + 32'(col_ff));
         default: rd_addr = AW'(32'(k_ff) * COLS);
      endcase
   end

   // Table memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= item.value;
      rd_data_ff <= mem[rd_addr];
   end

   assign dx_w   = cur_ff.value - xk_ff;
   assign span_w = rd_data_ff - xk_ff;

   pwli_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (dx_w),
      .divisor  (span_w_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Step rounding toward minus infinity equals an arithmetic shift.
   assign sum_wide = 50'(y0_ff) + (prod_ff >>> 16);

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         // The emit state decides the output register on its own.
         if (out_valid_ff && rsp_ready && state_ff != S_EMIT) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (item_valid && item_ready && item.cmd == CMD_QUERY) begin
                  cur_ff <= item;
                  k_ff   <= '0;
                  if (rows_lim < (RW+1)'(2)) begin
                     out_valid_ff <= 1'b1;
                     out_col_ff   <= '0;
                     out_val_ff   <= '0;
                     out_found_ff <= 1'b0;
                     out_last_ff  <= 1'b1;
                  end else begin
                     state_ff <= S_RDX0;
                  end
               end
            end
            S_RDX0: state_ff <= S_RDX;
            S_RDX: begin
               xk_ff    <= rd_data_ff;
               state_ff <= S_CMPX;
            end
            S_CMPX: state_ff <= S_WAIT;
            S_WAIT: begin
               // rd_data_ff holds x_(k+1), xk_ff holds x_k.
               if ($signed(cur_ff.value) >= xk_ff && $signed(cur_ff.value) < rd_data_ff) begin
                  span_w_ff <= span_w;
                  if (cols_lim < 4'd2) begin
                     out_valid_ff <= 1'b1;
                     out_col_ff   <= '0;
                     out_val_ff   <= '0;
                     out_found_ff <= 1'b1;
                     out_last_ff  <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     div_go_ff <= 1'b1;
                     col_ff    <= 4'd1;
                     state_ff  <= S_DIV;
                  end
               end else if (32'(k_ff) + 32'd2 >= 32'(rows_lim)) begin
                  out_valid_ff <= 1'b1;
                  out_col_ff   <= '0;
                  out_val_ff   <= '0;
                  out_found_ff <= 1'b0;
                  out_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  // Carry x_(k+1) forward as the next x_k.
                  xk_ff    <= rd_data_ff;
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_CMPX;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  q_ff     <= div_q;
                  state_ff <= S_RDY0;
               end
            end
            S_RDY0: state_ff <= S_RDY1;
            S_RDY1: begin
               y0_ff    <= rd_data_ff;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               dy_ff    <= 33'(rd_data_ff) - 33'(y0_ff);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               prod_ff  <= $signed({1'b0, q_ff}) * dy_ff;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_valid_ff <= 1'b1;
                  out_col_ff   <= col_ff[2:0];
                  out_found_ff <= 1'b1;
                  out_last_ff  <= (col_ff + 4'd1 == cols_lim);
                  if (sum_wide > 50'sd2147483647)       out_val_ff <= 32'h7FFF_FFFF;
                  else if (sum_wide < -50'sd2147483648) out_val_ff <= 32'h8000_0000;
                  else                                  out_val_ff <= sum_wide[31:0];
                  if (col_ff + 4'd1 == cols_lim) begin
                     state_ff <= S_IDLE;
                  end else begin
                     col_ff   <= col_ff + 4'd1;
                     state_ff <= S_RDY0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_column   = out_col_ff;
   assign rsp_interp_value = out_val_ff;
   assign rsp_found        = out_found_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ===== rtl/core/piecewise_linear_table_interp.sv =====
// Top level of the piecewise linear interpolation table.
// Depends on pwli_pkg, pwli_queue and pwli_engine.
//
//   channel  ports                         direction
//   req      req_valid/req_ready + fields  in: load or query item
//   rsp      rsp_valid/rsp_ready + fields  out: interpolated results
//   csr      csr_valid/csr_ready/index/data in: row_count, col_count
//
// Every item passes through the queue; a load is written into the table as the engine takes it.
// A query is accepted, reads x_0, then scans one breakpoint at a time through the compare
// and wait states, runs the bit-serial divider once for all y columns, and then reads,
// multiplies and saturates each y column in turn. Reset is synchronous; the table
// holds garbage until loaded. A stalled rsp holds the engine; the two-entry queue
// keeps taking req transfers until it fills.
module piecewise_linear_table_interp
   import pwli_pkg::*;
#(
   parameter int ROWS = 256,
   parameter int COLS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_row_index,
   input  logic [2:0]  req_col_index,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_column,
   output logic [31:0] rsp_interp_value,
   output logic        rsp_found,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [8:0] row_count_ff;
   logic [3:0] col_count_ff;
   item_type   push_item, pop_item;
   logic       pop_valid, pop_ready;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= 4'd2;
      end else if (csr_valid) begin
         if (csr_index == CSR_ROW_COUNT) row_count_ff <= csr_data[8:0];
         if (csr_index == CSR_COL_COUNT) col_count_ff <= csr_data[3:0];
      end
   end

   assign push_item = '{cmd: req_cmd, row_index: req_row_index,
                        col_index: req_col_index, value: req_value};

   pwli_queue u_queue (
      .clock, .reset,
      .push_valid (req_valid), .push_ready (req_ready), .push_item (push_item),
      .pop_valid  (pop_valid), .pop_ready  (pop_ready), .pop_item  (pop_item)
   );

   pwli_engine #(.ROWS(ROWS), .COLS(COLS)) u_engine (
      .clock, .reset,
      .item_valid (pop_valid), .item_ready (pop_ready), .item (pop_item),
      .row_count (row_count_ff), .col_count (col_count_ff),
      .rsp_valid, .rsp_ready, .rsp_out_column, .rsp_interp_value,
      .rsp_found, .rsp_last
   );

   // A not-found result never carries a column or value.
   a_notfound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_out_column == 3'd0)
      else $error("not-found result malformed");

   // A non-last found result is never column zero.
   a_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found && !rsp_last |-> rsp_out_column != 3'd0)
      else $error("intermediate result on column zero");

endmodule
